>>> design/chgn_pkg.sv
// Package for the counter-hash noise source: shared constants and the pipeline item type.
// Used by chgn_mix, counter_hash_gaussian_noise and the testbench; depends on nothing else.
package chgn_pkg;

   // Mixer
   localparam int          ROUNDS_DEF = 10;
   localparam logic [31:0] MIX_K      = 32'h9E37_79B9;

   // Fixed-point constants (Q32 unless noted)
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
   localparam logic [32:0] HALF_TURN  = 33'h0_8000_0000;
   localparam logic [32:0] QTR_TURN   = 33'h0_4000_0000;
   localparam logic [32:0] OCT_TURN   = 33'h0_2000_0000;
   localparam logic [32:0] PHASE_KNEE = 33'h0_8000_0001;
   localparam logic [60:0] U_HALF     = 61'd2147483649;
   localparam logic [32:0] HALFPI_Q32 = 33'h1_921F_B544;
   localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
   localparam logic [64:0] ROUND_HALF = 65'h0_8000_0000;

   // Cosine and sine series: divisors and their Q32 reciprocals
   localparam int SER_TERMS = 5;
   localparam logic [6:0]  COS_DIV [SER_TERMS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
   localparam logic [6:0]  SIN_DIV [SER_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] COS_RCP [SER_TERMS] = '{
      32'(64'd4294967296 / 90), 32'(64'd4294967296 / 56), 32'(64'd4294967296 / 30),
      32'(64'd4294967296 / 12), 32'(64'd4294967296 / 2)};
   localparam logic [31:0] SIN_RCP [SER_TERMS] = '{
      32'(64'd4294967296 / 110), 32'(64'd4294967296 / 72), 32'(64'd4294967296 / 42),
      32'(64'd4294967296 / 20), 32'(64'd4294967296 / 6)};

   // Log series coefficients 1/k in Q32, k = 13 then 11 down to 1
   localparam int HOR_TERMS = 6;
   localparam logic [32:0] HOR_C13 = 33'(64'd4294967296 / 13);
   localparam logic [32:0] HOR_C [HOR_TERMS] = '{
      33'(64'd4294967296 / 11), 33'(64'd4294967296 / 9), 33'(64'd4294967296 / 7),
      33'(64'd4294967296 / 5), 33'(64'd4294967296 / 3), 33'(64'd4294967296 / 1)};

   // Everything one item carries down the math pipeline
   typedef struct packed {
      logic [31:0] w1;       // mixed word of the counter
      logic [31:0] w2;       // mixed word of counter plus one
      logic [32:0] x1;       // w1 + 1
      logic [32:0] p;        // phase, then folded phase
      logic [60:0] un;       // uniform numerator
      logic [28:0] uq0;      // uniform quotient estimate
      logic [31:0] sample;   // uniform sample, final sample at the end
      logic        neg;
      logic        use_sin;
      logic [5:0]  e;        // exponent of x1
      logic [31:0] a;        // angle
      logic [31:0] y;        // angle squared
      logic [32:0] g;        // series accumulator
      logic [31:0] v;        // series product
      logic [31:0] q0;       // series quotient estimate
      logic [32:0] cmag;     // cosine magnitude
      logic [31:0] f;        // mantissa fraction
      logic [34:0] rem;      // divider remainder
      logic [30:0] t;        // divider quotient
      logic [29:0] t2;
      logic [32:0] acc;      // log series accumulator
      logic [32:0] lnm;
      logic [61:0] n;        // square root radicand
      logic [61:0] res;      // square root result
   } item_type;

endpackage

>>> design/counter_hash_gaussian_noise.sv
// Counter-hash noise source: fixed-point uniform or Box-Muller gaussian sample per counter.
// Depends on chgn_pkg and chgn_mix.
//
// One counter beat is taken every cycle unless the output stalls; one result beat leaves per
// counter, in order. ROUNDS mixer stages lead into a 92-stage math pipeline made of
// phase fold and angle, three stages per cosine/sine series term, a one-bit-per-stage
// 31-stage restoring divider for the log argument, six log series stages, and a 31-stage
// digit-by-digit square root, then the output multiply. A stalled output freezes the whole
// pipeline; nothing is lost or repeated. The distribution register is written through the
// csr channel, which is always ready; write it only while no beat is in flight.
module counter_hash_gaussian_noise #(
   parameter int ROUNDS = chgn_pkg::ROUNDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_counter,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [31:0] rsp_raw_word,
   output logic signed [31:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_distribution
);
   import chgn_pkg::*;

   localparam int S_PREP  = 0;
   localparam int S_FOLD  = S_PREP + 1;
   localparam int S_ANG   = S_FOLD + 1;
   localparam int S_SQ    = S_ANG + 1;
   localparam int S_SER   = S_SQ + 1;
   localparam int S_SIN   = S_SER + 3 * SER_TERMS;
   localparam int DIV_LEN = 31;
   localparam int S_DIV   = S_SIN + 1;
   localparam int S_T2    = S_DIV + DIV_LEN;
   localparam int S_HOR   = S_T2 + 1;
   localparam int S_LNM   = S_HOR + HOR_TERMS;
   localparam int S_LOG   = S_LNM + 1;
   localparam int SQ_LEN  = 31;
   localparam int S_SQRT  = S_LOG + 1;
   localparam int S_OUT   = S_SQRT + SQ_LEN;
   localparam int NP      = S_OUT + 1;

   logic          en;
   logic          dist_ff;
   logic          mix_vld;
   logic [31:0]   mix_w1;
   logic [31:0]   mix_w2;
   item_type      mix_item;
   item_type      pipe_ff [NP];
   item_type      pipe_in [NP];
   logic [NP-1:0] vld_ff;
   logic [NP-1:0] vld_in;

   // ---- stage functions ----

   function automatic item_type prep_stage(item_type s);
      item_type    o;
      logic [32:0] x2;
      o      = s;
      o.x1   = {1'b0, s.w1} + 33'd1;
      x2     = {1'b0, s.w2} + 33'd1;
      o.p    = (x2 <= PHASE_KNEE) ? x2 - 33'd1 : x2 - 33'd2;
      o.un   = {o.x1, 28'd0} + U_HALF;
      o.uq0  = o.un[60:32];
      return o;
   endfunction

   function automatic item_type fold_stage(item_type s);
      item_type    o;
      logic [32:0] p1;
      logic [32:0] p2;
      logic        low;
      o        = s;
      low      = s.un < ({s.uq0, 32'd0} + {31'd0, s.uq0, 1'b0});
      o.sample = {3'd0, s.uq0 - 29'(low)};
      p1        = (s.p > HALF_TURN) ? ONE_Q32 - s.p : s.p;
      o.neg     = p1 > QTR_TURN;
      p2        = o.neg ? HALF_TURN - p1 : p1;
      o.use_sin = p2 > OCT_TURN;
      o.p       = o.use_sin ? QTR_TURN - p2 : p2;
      o.e = 6'd0;
      for (int i = 0; i < 33; i++) begin
         if (s.x1[i]) o.e = 6'(i);
      end
      return o;
   endfunction

   function automatic item_type ang_stage(item_type s);
      item_type    o;
      logic [62:0] prod;
      logic [32:0] sh;
      o     = s;
      prod  = 63'(s.p[29:0]) * 63'(HALFPI_Q32);
      o.a   = prod[61:30];
      sh    = s.x1 << (6'd32 - s.e);
      o.f   = sh[31:0];
      o.rem = {2'b00, sh[31:0], 1'b0};
      o.t   = '0;
      return o;
   endfunction

   function automatic item_type sq_stage(item_type s);
      item_type    o;
      logic [63:0] prod;
      o    = s;
      prod = 64'(s.a) * 64'(s.a);
      o.y  = prod[63:32];
      o.g  = ONE_Q32;
      return o;
   endfunction

   function automatic item_type ser_mul(item_type s);
      item_type    o;
      logic [64:0] prod;
      o    = s;
      prod = 65'(s.y) * 65'(s.g);
      o.v  = prod[63:32];
      return o;
   endfunction

   function automatic item_type ser_rcp(item_type s, logic [2:0] i);
      item_type    o;
      logic [31:0] rcp;
      logic [63:0] prod;
      o    = s;
      rcp  = s.use_sin ? SIN_RCP[i] : COS_RCP[i];
      prod = 64'(s.v) * 64'(rcp);
      o.q0 = prod[63:32];
      return o;
   endfunction

   function automatic item_type ser_fix(item_type s, logic [2:0] i);
      item_type    o;
      logic [6:0]  d;
      logic [31:0] r;
      logic [31:0] q;
      o   = s;
      d   = s.use_sin ? SIN_DIV[i] : COS_DIV[i];
      r   = s.v - s.q0 * {25'd0, d};
      q   = s.q0 + 32'(r >= {25'd0, d});
      o.g = ONE_Q32 - {1'b0, q};
      return o;
   endfunction

   function automatic item_type sin_stage(item_type s);
      item_type    o;
      logic [64:0] prod;
      o      = s;
      prod   = 65'(s.a) * 65'(s.g);
      o.cmag = s.use_sin ? prod[64:32] : s.g;
      return o;
   endfunction

   function automatic item_type div_step(item_type s, logic [4:0] b);
      item_type    o;
      logic [34:0] rs;
      logic [34:0] d;
      o  = s;
      rs = {s.rem[33:0], 1'b0};
      d  = {3'b010, s.f};
      if (rs >= d) begin
         o.rem  = rs - d;
         o.t[b] = 1'b1;
      end else begin
         o.rem = rs;
      end
      return o;
   endfunction

   function automatic item_type t2_stage(item_type s);
      item_type    o;
      logic [61:0] prod;
      o     = s;
      prod  = 62'(s.t) * 62'(s.t);
      o.t2  = prod[61:32];
      o.acc = HOR_C13;
      return o;
   endfunction

   function automatic item_type hor_step(item_type s, logic [2:0] h);
      item_type    o;
      logic [62:0] prod;
      o     = s;
      prod  = 63'(s.acc) * 63'(s.t2);
      o.acc = HOR_C[h] + {2'b00, prod[62:32]};
      return o;
   endfunction

   function automatic item_type lnm_stage(item_type s);
      item_type    o;
      logic [63:0] prod;
      o     = s;
      prod  = 64'(s.t) * 64'(s.acc);
      o.lnm = prod[63:31];
      return o;
   endfunction

   function automatic item_type log_stage(item_type s);
      item_type    o;
      logic [37:0] scale;
      logic [37:0] lval;
      o     = s;
      scale = 38'(6'd32 - s.e) * 38'(LN2_Q32);
      lval  = scale - 38'(s.lnm) + 38'd2;
      o.n   = {lval[36:0], 25'd0};
      o.res = '0;
      return o;
   endfunction

   function automatic item_type sqrt_step(item_type s, logic [5:0] sh);
      item_type    o;
      logic [61:0] bitv;
      logic [62:0] trial;
      o     = s;
      bitv  = 62'd1 << sh;
      trial = 63'(s.res) + 63'(bitv);
      if (63'(s.n) >= trial) begin
         o.n   = s.n - trial[61:0];
         o.res = (s.res >> 1) + bitv;
      end else begin
         o.res = s.res >> 1;
      end
      return o;
   endfunction

   function automatic item_type out_stage(item_type s, logic gauss_sel);
      item_type    o;
      logic [64:0] prod;
      logic [31:0] mag;
      logic [31:0] gauss;
      o        = s;
      prod     = 65'(s.res[30:0]) * 65'(s.cmag) + ROUND_HALF;
      mag      = prod[63:32];
      gauss    = s.neg ? 32'd0 - mag : mag;
      o.sample = gauss_sel ? gauss : s.sample;
      return o;
   endfunction

   // Freeze everything while the output beat is held
   assign en        = !(vld_ff[S_OUT] && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // Hold the distribution register
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         dist_ff <= csr_distribution;
      end
   end

   chgn_mix #(
      .ROUNDS(ROUNDS)
   ) u_mix (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_lo    (req_counter[31:0]),
      .out_valid(mix_vld),
      .out_w1   (mix_w1),
      .out_w2   (mix_w2)
   );

   // Load mixed words into a fresh item
   always_comb begin
      mix_item    = '0;
      mix_item.w1 = mix_w1;
      mix_item.w2 = mix_w2;
   end

   // Compute next value of every stage
   always_comb begin
      pipe_in[S_PREP] = prep_stage(mix_item);
      pipe_in[S_FOLD] = fold_stage(pipe_ff[S_PREP]);
      pipe_in[S_ANG]  = ang_stage(pipe_ff[S_FOLD]);
      pipe_in[S_SQ]   = sq_stage(pipe_ff[S_ANG]);
      for (int i = 0; i < SER_TERMS; i++) begin
         pipe_in[S_SER + 3*i]     = ser_mul(pipe_ff[S_SER + 3*i - 1]);
         pipe_in[S_SER + 3*i + 1] = ser_rcp(pipe_ff[S_SER + 3*i], 3'(i));
         pipe_in[S_SER + 3*i + 2] = ser_fix(pipe_ff[S_SER + 3*i + 1], 3'(i));
      end
      pipe_in[S_SIN] = sin_stage(pipe_ff[S_SIN - 1]);
      for (int j = 0; j < DIV_LEN; j++) begin
         pipe_in[S_DIV + j] = div_step(pipe_ff[S_DIV + j - 1], 5'(DIV_LEN - 1 - j));
      end
      pipe_in[S_T2] = t2_stage(pipe_ff[S_T2 - 1]);
      for (int h = 0; h < HOR_TERMS; h++) begin
         pipe_in[S_HOR + h] = hor_step(pipe_ff[S_HOR + h - 1], 3'(h));
      end
      pipe_in[S_LNM] = lnm_stage(pipe_ff[S_LNM - 1]);
      pipe_in[S_LOG] = log_stage(pipe_ff[S_LOG - 1]);
      for (int j = 0; j < SQ_LEN; j++) begin
         pipe_in[S_SQRT + j] = sqrt_step(pipe_ff[S_SQRT + j - 1], 6'(2 * (SQ_LEN - 1 - j)));
      end
      pipe_in[S_OUT] = out_stage(pipe_ff[S_OUT - 1], dist_ff);
   end

   // Shift valid bits
   always_comb begin
      vld_in[0] = mix_vld;
      for (int k = 1; k < NP; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_valid    = vld_ff[S_OUT];
   assign rsp_raw_word = pipe_ff[S_OUT].w1;
   assign rsp_sample   = signed'(pipe_ff[S_OUT].sample);

`ifndef ASSERT_OFF
   // Divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_T2 - 1] |-> pipe_ff[S_T2 - 1].rem < {3'b010, pipe_ff[S_T2 - 1].f})
      else $error("divider remainder not below divisor");

   // Square root result fits 31 bits
   a_sqrt_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_OUT - 1] |-> pipe_ff[S_OUT - 1].res[61:31] == 31'd0)
      else $error("square root result out of range");

   // Cosine magnitude never exceeds one
   a_cmag_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_OUT] |-> pipe_ff[S_OUT].cmag <= ONE_Q32)
      else $error("cosine magnitude above one");

   // Held output freezes the whole pipeline
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved under stall");

   // No result valid right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> design/chgn_mix.sv
// Counter mixer: one pipeline stage per round, mixing the counter word and the word plus one.
// Depends on chgn_pkg for the mixing constant.
module chgn_mix #(
   parameter int ROUNDS = chgn_pkg::ROUNDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_lo,
   output logic        out_valid,
   output logic [31:0] out_w1,
   output logic [31:0] out_w2
);
   import chgn_pkg::*;

   logic [31:0]       src1  [ROUNDS];
   logic [31:0]       src2  [ROUNDS];
   logic [31:0]       w1_ff [ROUNDS];
   logic [31:0]       w1_in [ROUNDS];
   logic [31:0]       w2_ff [ROUNDS];
   logic [31:0]       w2_in [ROUNDS];
   logic [ROUNDS-1:0] vld_ff;
   logic [ROUNDS-1:0] vld_in;

   function automatic logic [31:0] mix_round(logic [31:0] w, int r);
      logic [31:0] key;
      key = 32'(MIX_K * 32'(r + 1));
      return (w * MIX_K) ^ key;
   endfunction

   // Apply one round per stage
   always_comb begin
      src1[0]   = in_lo;
      src2[0]   = in_lo + 32'd1;
      vld_in[0] = in_valid;
      for (int r = 1; r < ROUNDS; r++) begin
         src1[r]   = w1_ff[r-1];
         src2[r]   = w2_ff[r-1];
         vld_in[r] = vld_ff[r-1];
      end
      for (int r = 0; r < ROUNDS; r++) begin
         w1_in[r] = mix_round(src1[r], r);
         w2_in[r] = mix_round(src2[r], r);
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance words
   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff <= w1_in;
         w2_ff <= w2_in;
      end
   end

   assign out_valid = vld_ff[ROUNDS-1];
   assign out_w1    = w1_ff[ROUNDS-1];
   assign out_w2    = w2_ff[ROUNDS-1];

endmodule

>>> bench/testbench.sv
// Testbench for counter_hash_gaussian_noise: directed counters, then random counters,
// in uniform and gaussian mode, each result checked against a bit-exact predictor.
// Depends on chgn_pkg and the design sources only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import chgn_pkg::*;

   typedef logic [63:0] u64_type;

   localparam int         LATENCY   = ROUNDS_DEF + 92;
   localparam int         RAND_ITEMS = 750;
   localparam int         LIMIT     = 400000;
   localparam u64_type    K_ONE     = 64'd4294967296;
   localparam u64_type    K_UDEN    = 64'd4294967298;
   localparam u64_type    K_LN2     = 64'hB172_17F8;
   localparam u64_type    K_HALFPI  = 64'h1_921F_B544;
   localparam logic       DIST_UNIFORM  = 1'b0;
   localparam logic       DIST_GAUSSIAN = 1'b1;

   typedef struct {
      logic [31:0] raw_word;
      logic [31:0] sample;
   } beat_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [63:0] req_counter;
   logic               rsp_valid;
   logic               rsp_stall;
   logic        [31:0] rsp_raw_word;
   logic signed [31:0] rsp_sample;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_distribution;

   counter_hash_gaussian_noise dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_counter(req_counter),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_raw_word(rsp_raw_word), .rsp_sample(rsp_sample),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_distribution(csr_distribution)
   );

   beat_type    pending_q[$];
   logic        gauss_mode;
   int          errors;
   int          results_seen;
   int          cycles;
   logic        calm;
   logic        hold_off;
   logic        rsp_taken;
   int          rx_wait;

   // Directed counters: extremes, high word ignored, low word wrap on counter plus one
   localparam int N_DIRECTED = 12;
   localparam u64_type DIRECTED_COUNTERS [N_DIRECTED] = '{
      64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_0000_0000, 64'h0000_0000_FFFF_FFFF,
      64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_FFFE, 64'h0000_0000_8000_0000,
      64'h0000_0000_7FFF_FFFF, 64'hA5A5_5A5A_DEAD_BEEF, 64'h5A5A_A5A5_2152_4110};

   // ---------------- predictor ----------------
   function automatic logic [31:0] mix_rounds(logic [31:0] w);
      for (int r = 0; r < ROUNDS_DEF; r++) begin
         w = w * MIX_K;
         w ^= 32'(MIX_K * 32'(r + 1));
      end
      return w;
   endfunction

   // -ln(x / (2^32+2)) in Q32, x in [1, 2^32]
   function automatic u64_type minus_log(u64_type x);
      u64_type e, m, t, t2, acc, lnm;
      e = 0;
      while (e < 32 && (x >> (e + 1)) != 0) e++;
      m = x << (32 - e);
      t = ((m - K_ONE) << 32) / (m + K_ONE);
      t2 = (t * t) >> 32;
      acc = K_ONE / 64'd13;
      for (int k = 11; k >= 1; k -= 2)
         acc = K_ONE / u64_type'(k) + ((acc * t2) >> 32);
      lnm = (t * acc) >> 31;
      return (64'd32 - e) * K_LN2 - lnm + 64'd2;
   endfunction

   function automatic u64_type int_sqrt(u64_type n);
      u64_type res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic u64_type trig_series(u64_type y, logic sine);
      u64_type g, d;
      g = K_ONE;
      for (int i = 0; i < SER_TERMS; i++) begin
         d = sine ? u64_type'(SIN_DIV[i]) : u64_type'(COS_DIV[i]);
         g = K_ONE - (((y * g) >> 32) / d);
      end
      return g;
   endfunction

   // Cosine of a phase in Q32 turns: magnitude out, sign returned
   function automatic logic cos_of_phase(u64_type p, output u64_type mag);
      logic neg, use_sin;
      u64_type a, y;
      neg = 1'b0;
      use_sin = 1'b0;
      if (p > (64'd1 << 31)) p = K_ONE - p;
      if (p > (64'd1 << 30)) begin
         p = (64'd1 << 31) - p;
         neg = 1'b1;
      end
      if (p > (64'd1 << 29)) begin
         p = (64'd1 << 30) - p;
         use_sin = 1'b1;
      end
      a = (p * K_HALFPI) >> 30;
      y = (a * a) >> 32;
      mag = use_sin ? ((a * trig_series(y, 1'b1)) >> 32) : trig_series(y, 1'b0);
      return neg;
   endfunction

   function automatic beat_type predict_noise(u64_type counter, logic gauss);
      beat_type nb;
      logic [31:0] lo, w2;
      u64_type x1, x2, p, r, cmag, mag;
      logic neg;
      lo = counter[31:0];
      nb.raw_word = mix_rounds(lo);
      x1 = u64_type'(nb.raw_word) + 64'd1;
      if (!gauss) begin
         nb.sample = 32'(((x1 << 28) + K_UDEN / 2) / K_UDEN);
      end else begin
         w2 = mix_rounds(lo + 32'd1);
         x2 = u64_type'(w2) + 64'd1;
         p = x2 - (64'd2 * x2 + K_UDEN - 64'd1) / K_UDEN;
         r = int_sqrt((64'd2 * minus_log(x1)) << 24);
         neg = cos_of_phase(p, cmag);
         mag = (r * cmag + (64'd1 << 31)) >> 32;
         nb.sample = neg ? 32'(0) - 32'(mag) : 32'(mag);
      end
      return nb;
   endfunction

   // ---------------- clock, reset, limit ----------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------- result side ----------------
   // Sample between edges: a beat seen here is taken at the next rising edge
   always @(negedge clock) begin
      beat_type exp_b;
      rsp_taken = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         results_seen++;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected beat raw_word=%h sample=%h", $time,
                     rsp_raw_word, rsp_sample);
            errors++;
         end else begin
            exp_b = pending_q.pop_front();
            if (rsp_raw_word !== exp_b.raw_word) begin
               $display("%0t: raw_word expected %h actual %h", $time,
                        exp_b.raw_word, rsp_raw_word);
               errors++;
            end
            if (rsp_sample !== exp_b.sample) begin
               $display("%0t: sample expected %h actual %h", $time,
                        exp_b.sample, rsp_sample);
               errors++;
            end
         end
      end
   end

   // Stall the result side: a random wait per beat unless calm, plus the long hold-off
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_stall <= 1'b1;
         rx_wait <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rsp_taken) begin
         draw = calm ? 0 : $urandom_range(0, 16);
         rx_wait <= (draw > 0) ? draw - 1 : 0;
         rsp_stall <= (draw > 0);
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------- input side ----------------
   task automatic send_counter(u64_type counter);
      int gap;
      logic ok;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_counter <= counter;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      pending_q.push_back(predict_noise(counter, gauss_mode));
   endtask

   // Write the distribution register once the pipe is empty
   task automatic write_distribution(logic mode);
      logic ok;
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_distribution <= mode;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      gauss_mode = mode;
   endtask

   function automatic u64_type random_counter();
      u64_type c;
      c = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: c[31:0] = 32'hFFFF_FFFF;
         1: c[31:0] = 32'($urandom_range(0, 3));
         default: ;
      endcase
      return c;
   endfunction

   // Long receiver hold-off, counted here while the sender keeps going
   initial begin
      hold_off = 1'b0;
      wait (results_seen > 200);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (3 * LATENCY) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_counter = '0;
      csr_valid = 1'b0;
      csr_distribution = 1'b0;
      gauss_mode = DIST_UNIFORM;
      errors = 0;
      results_seen = 0;
      cycles = 0;
      calm = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass in the reset mode, then in gaussian mode
      for (int i = 0; i < N_DIRECTED; i++) send_counter(DIRECTED_COUNTERS[i]);
      write_distribution(DIST_GAUSSIAN);
      for (int i = 0; i < N_DIRECTED; i++) send_counter(DIRECTED_COUNTERS[i]);

      // Random phases, alternating the mode, some of them without idling
      for (int ph = 0; ph < 6; ph++) begin
         write_distribution(ph[0] ? DIST_GAUSSIAN : DIST_UNIFORM);
         calm <= (ph == 2 || ph == 5);
         for (int i = 0; i < RAND_ITEMS / 6; i++) send_counter(random_counter());
      end
      req_valid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("run covered %0d results in uniform and gaussian mode,", results_seen);
      $display("with random idling on both sides and one long result hold-off");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
